[src/slcan_line_decoder_defines.svh]
// ----------------------------------------------------------------------------
// slcan line decoder assertion macros
// shared concurrent check forms used by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef SLCAN_LINE_DECODER_DEFINES_SVH
`define SLCAN_LINE_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising clk outside reset
`define SLCAN_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLCAN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/slcan_pkg.sv]
// ----------------------------------------------------------------------------
// slcan package
// character codes, frame type and hex digit decoding for the line decoder
// ----------------------------------------------------------------------------
package slcan_pkg;

	localparam int DEF_MAX_DATA_BYTES = 8;

	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_EXT_T   = 8'h54; // 'T'
	localparam logic [7:0] CHAR_EXT_R   = 8'h52; // 'R'
	localparam logic [7:0] CHAR_STD_T   = 8'h74; // 't'
	localparam logic [7:0] CHAR_STD_R   = 8'h72; // 'r'

	localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
	localparam logic [3:0] STD_ID_DIGITS = 4'd3;
	localparam logic [4:0] MIN_LINE      = 5'd5;
	localparam logic [4:0] POS_MAX       = 5'd31;

	typedef struct packed {
		logic [31:0] can_id;
		logic        extended;
		logic [3:0]  data_length;
		logic [63:0] payload;
	} frame_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			// letters a-f sit at 1..6 in the low nibble for either case
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

[src/slcan_parse.sv]
// ----------------------------------------------------------------------------
// slcan line parser
// input character register and per-line state; builds one frame per well formed line
// ----------------------------------------------------------------------------
module slcan_parse import slcan_pkg::*; #(
	parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       slot_free,
	output logic       load,
	output frame_t     frame
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic [4:0]  pos_q;
	logic        ext_q;
	logic        bad_q;
	logic [31:0] id_q;
	logic [3:0]  decl_q;
	logic [3:0]  hi_q;
	logic [3:0]  nbytes_q;
	logic [63:0] data_q;

	logic [4:0]  pos_d;
	logic        ext_d;
	logic        bad_d;
	logic [31:0] id_d;
	logic [3:0]  decl_d;
	logic [3:0]  hi_d;
	logic [3:0]  nbytes_d;
	logic [63:0] data_d;

	hex_t        hex;
	logic [4:0]  id_digits;
	logic [4:0]  q;
	logic        is_cr;
	logic        line_ok;

	assign advance  = valid_s1 && slot_free;
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign hex       = hex_decode(byte_s1);
	assign id_digits = {1'b0, (ext_q ? EXT_ID_DIGITS : STD_ID_DIGITS)};
	assign q         = pos_q - (id_digits + 5'd2);
	assign is_cr     = (byte_s1 == CHAR_CR);
	assign line_ok   = !bad_q && (pos_q >= MIN_LINE) && (pos_q >= id_digits + 5'd2);

	always_comb begin
		pos_d    = pos_q;
		ext_d    = ext_q;
		bad_d    = bad_q;
		id_d     = id_q;
		decl_d   = decl_q;
		hi_d     = hi_q;
		nbytes_d = nbytes_q;
		data_d   = data_q;
		if (is_cr) begin
			pos_d    = '0;
			ext_d    = 1'b0;
			bad_d    = 1'b0;
			id_d     = '0;
			decl_d   = '0;
			hi_d     = '0;
			nbytes_d = '0;
			data_d   = '0;
		end else begin
			if (pos_q != POS_MAX) begin
				pos_d = pos_q + 5'd1;
			end
			if (!bad_q) begin
				priority if (pos_q == 5'd0) begin
					if (byte_s1 == CHAR_EXT_T || byte_s1 == CHAR_EXT_R) begin
						ext_d = 1'b1;
					end else if (byte_s1 == CHAR_STD_T || byte_s1 == CHAR_STD_R) begin
						ext_d = 1'b0;
					end else begin
						bad_d = 1'b1;
					end
				end else if (pos_q <= id_digits) begin
					if (!hex.ok) begin
						bad_d = 1'b1;
					end else begin
						id_d = {id_q[27:0], hex.val};
					end
				end else if (pos_q == id_digits + 5'd1) begin
					if (!hex.ok || hex.val > 4'(MAX_DATA_BYTES)) begin
						bad_d = 1'b1;
					end else begin
						decl_d = hex.val;
					end
				end else if (q < {decl_q, 1'b0}) begin
					if (!hex.ok) begin
						bad_d = 1'b1;
					end else if (!q[0]) begin
						hi_d = hex.val;
					end else if (!nbytes_q[3]) begin
						// slot is still zero, so a plain write equals an or
						data_d[{nbytes_q[2:0], 3'b000} +: 8] = {hi_q, hex.val};
						nbytes_d = nbytes_q + 4'd1;
					end
				end else begin
					// characters past the declared payload are ignored
					hi_d = hi_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ext_q    <= 1'b0;
			bad_q    <= 1'b0;
			id_q     <= '0;
			decl_q   <= '0;
			hi_q     <= '0;
			nbytes_q <= '0;
			data_q   <= '0;
		end else if (advance) begin
			pos_q    <= pos_d;
			ext_q    <= ext_d;
			bad_q    <= bad_d;
			id_q     <= id_d;
			decl_q   <= decl_d;
			hi_q     <= hi_d;
			nbytes_q <= nbytes_d;
			data_q   <= data_d;
		end
	end

	assign load              = advance && is_cr && line_ok;
	assign frame.can_id      = id_q;
	assign frame.extended    = ext_q;
	assign frame.data_length = nbytes_q;
	assign frame.payload     = data_q;

endmodule

[src/slcan_out.sv]
// ----------------------------------------------------------------------------
// slcan output register
// holds one finished frame until the receiver takes the transaction
// ----------------------------------------------------------------------------
module slcan_out import slcan_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  frame_t      frame,
	output logic        slot_free,
	output logic        frame_valid,
	input  logic        frame_ready,
	output logic [31:0] can_id,
	output logic        extended,
	output logic [3:0]  data_length,
	output logic [63:0] payload
);

	logic   valid_q;
	frame_t frame_q;

	assign slot_free = !valid_q || frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

	assign frame_valid = valid_q;
	assign can_id      = frame_q.can_id;
	assign extended    = frame_q.extended;
	assign data_length = frame_q.data_length;
	assign payload     = frame_q.payload;

endmodule

[src/slcan_line_decoder.sv]
// ----------------------------------------------------------------------------
// slcan line decoder
// ascii serial line to can frame parser, when not stalled one character per cycle
// ----------------------------------------------------------------------------
// usage:
//   rx channel (rx_valid/rx_ready/rx_byte) carries one received character per
//   transaction. a carriage return closes the line; if the line is well formed
//   one frame transaction follows on the frame channel (frame_valid/
//   frame_ready with can_id, extended, data_length, payload).
//   path: an accepted carriage return is captured in the input register, and the
//   frame is then written into the result register once that register is free,
//   which presents it on the frame channel.
//   throughput: one character per cycle unless stalled, set by the single input
//   register feeding the line state and the result register.
//   stall: while a frame waits in the result register and frame_ready is low,
//   the input register holds its character and rx_ready drops once it is full.
//   reset: arst_n clears the line state and both valid flags; the first
//   character after reset starts a new line.
// ----------------------------------------------------------------------------
`include "slcan_line_decoder_defines.svh"

module slcan_line_decoder import slcan_pkg::*; #(
	parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        frame_valid,
	input  logic        frame_ready,
	output logic [31:0] can_id,
	output logic        extended,
	output logic [3:0]  data_length,
	output logic [63:0] payload
);

	logic   slot_free;
	logic   load;
	frame_t frame;

	slcan_parse #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.slot_free(slot_free),
		.load     (load),
		.frame    (frame)
	);

	slcan_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.frame      (frame),
		.slot_free  (slot_free),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.can_id     (can_id),
		.extended   (extended),
		.data_length(data_length),
		.payload    (payload)
	);

	// a frame may only be loaded into a free result slot
	`SLCAN_ASSERT_SAME(a_load_free, load, slot_free, "frame loaded over a waiting frame")
	// decoded length never exceeds the configured maximum
	`SLCAN_ASSERT_SAME(a_len_max, frame_valid, data_length <= 4'(MAX_DATA_BYTES),
		"data length above maximum")
	// a standard identifier has only three hex digits
	`SLCAN_ASSERT_SAME(a_std_id, frame_valid && !extended, can_id[31:12] == 20'd0,
		"standard identifier too wide")
	// a load always produces a waiting frame next cycle
	`SLCAN_ASSERT_NEXT(a_load_shown, load, frame_valid, "loaded frame not presented")

endmodule
